[rtl/ptbp_pkg.sv]
// ----------------------------------------------------------------------------
// ptbp_pkg: shared types and constants for the play-time block
// Field widths, register indexes, format kinds, FSM states and the control
// struct used between the sequencer and its serial units.
// ----------------------------------------------------------------------------
`default_nettype none

package ptbp_pkg;

    localparam int POSITION_BITS_DEF = 40;
    localparam int SIZE_BITS         = 40;
    localparam int BLOCK_BITS        = 20;
    localparam int BITRATE_BITS      = 16;
    localparam int KIND_BITS         = 2;
    localparam int PERCENT_BITS      = 8;
    localparam int MINUTE_BITS       = 16;
    localparam int SECOND_BITS       = 6;
    localparam int CFG_INDEX_BITS    = 3;
    localparam int DIVISOR_BITS      = SIZE_BITS;
    localparam int TDIV_BITS         = 26;

    localparam int unsigned FRAMES_PER_SEC = 50;
    localparam int unsigned MS_PER_SEC     = 1000;
    localparam int unsigned SEC_PER_MIN    = 60;
    localparam int unsigned PERCENT_SCALE  = 100;
    localparam int unsigned BYTE_SHIFT     = 3;   // times eight bits per byte

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_FORMAT_KIND   = 3'd0,
        CFG_FILE_SIZE     = 3'd1,
        CFG_HEADER_OFFSET = 3'd2,
        CFG_BLOCK_SIZE    = 3'd3,
        CFG_BITRATE_KBPS  = 3'd4
    } cfg_index_t;

    typedef enum logic [KIND_BITS-1:0] {
        FMT_FRAME   = 2'd0,
        FMT_BITRATE = 2'd1,
        FMT_BPS     = 2'd2
    } fmt_kind_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL,
        S_LDP,
        S_DIVP,
        S_LDE,
        S_DIVE,
        S_LDT,
        S_DIVT,
        S_FIN
    } ptbp_state_t;

    typedef struct packed {
        logic load;
        logic step;
    } seq_ctl_t;

endpackage

`default_nettype wire

[rtl/play_time_from_byte_position.sv]
// ----------------------------------------------------------------------------
// play_time_from_byte_position: played percent and play time from a position
// Sequencer, configuration registers and held results around a bit-serial
// multiplier, one shared serial divider and a serial split into min:sec.
//
//   channel | handshake              | payload
//   --------+------------------------+-----------------------------------------
//   in      | in_valid / in_stall    | position
//   out     | out_valid / out_stall  | percent, minute, second, total_*
//   cfg     | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// Each item runs one serial multiply pass and three passes of the shared
// divider over NB = max(POSITION_BITS, 40) + 7 bits, each one bit per cycle,
// plus load and hand-over states.
// Reset clears the registers (format kind to bitrate based) and held results.
// in_stall is low only while the sequencer is idle; a result waiting in the
// output register does not block the next transfer in.
// ----------------------------------------------------------------------------
`default_nettype none

module play_time_from_byte_position #(
    parameter int POSITION_BITS = ptbp_pkg::POSITION_BITS_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                in_valid,
    output logic                                     in_stall,
    input  wire logic [POSITION_BITS-1:0]            position,
    output logic                                     out_valid,
    input  wire logic                                out_stall,
    output logic [ptbp_pkg::PERCENT_BITS-1:0]        percent,
    output logic [ptbp_pkg::MINUTE_BITS-1:0]         minute,
    output logic [ptbp_pkg::SECOND_BITS-1:0]         second,
    output logic [ptbp_pkg::MINUTE_BITS-1:0]         total_minute,
    output logic [ptbp_pkg::SECOND_BITS-1:0]         total_second,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [ptbp_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  wire logic [ptbp_pkg::SIZE_BITS-1:0]      cfg_data
);

    localparam int PW = POSITION_BITS;
    localparam int WX = (PW > ptbp_pkg::SIZE_BITS) ? PW : ptbp_pkg::SIZE_BITS;
    localparam int NB = WX + 7;
    localparam int CW = $clog2(NB);
    localparam int DW = ptbp_pkg::DIVISOR_BITS;
    localparam int TW = ptbp_pkg::TDIV_BITS;
    localparam int PB = ptbp_pkg::PERCENT_BITS;
    localparam int MB = ptbp_pkg::MINUTE_BITS;
    localparam int SB = ptbp_pkg::SECOND_BITS;

    // configuration
    logic [ptbp_pkg::KIND_BITS-1:0]    format_kind_reg;
    logic [ptbp_pkg::SIZE_BITS-1:0]    file_size_reg;
    logic [ptbp_pkg::SIZE_BITS-1:0]    header_offset_reg;
    logic [ptbp_pkg::BLOCK_BITS-1:0]   block_size_reg;
    logic [ptbp_pkg::BITRATE_BITS-1:0] bitrate_reg;

    // sequencer
    ptbp_pkg::ptbp_state_t state_reg, state_next;
    logic [CW-1:0]         cnt_reg, cnt_next;
    logic                  run;
    logic                  last;
    logic                  accept;
    logic                  out_load;
    ptbp_pkg::seq_ctl_t    mul_ctl, div_ctl, spl_ctl;

    // held results and output register
    logic [PB-1:0] held_pct_reg;
    logic [MB-1:0] held_min_reg;
    logic [SB-1:0] held_sec_reg;
    logic [MB-1:0] held_tmin_reg;
    logic [SB-1:0] held_tsec_reg;
    logic          out_valid_reg;
    logic [PB-1:0] percent_reg;
    logic [MB-1:0] minute_reg;
    logic [SB-1:0] second_reg;
    logic [MB-1:0] tmin_reg;
    logic [SB-1:0] tsec_reg;

    // datapath
    logic [PW-1:0] pos_reg;
    logic [PB-1:0] pct_acc_reg;
    logic          pct_sat_reg;
    logic [PB-1:0] pct_result;
    logic [NB-1:0] product;
    logic [NB-1:0] dividend;
    logic [DW-1:0] divisor;
    logic          qbit;
    logic [MB-1:0] spl_minute;
    logic [SB-1:0] spl_second;
    logic          is_bitrate;
    logic          fs_nz;
    logic          div_nz;
    logic [TW-1:0] bs50;
    logic [TW-1:0] br1000;
    logic [DW-1:0] tdiv;
    logic [WX-1:0] pos_ext;
    logic [WX-1:0] off_ext;
    logic [WX-1:0] done_bytes;
    logic [ptbp_pkg::SIZE_BITS-1:0] all_bytes;
    logic [NB-1:0] done_dvd;
    logic [NB-1:0] all_dvd;
    logic          pct_clear;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            format_kind_reg   <= ptbp_pkg::FMT_BITRATE;
            file_size_reg     <= '0;
            header_offset_reg <= '0;
            block_size_reg    <= '0;
            bitrate_reg       <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                ptbp_pkg::CFG_FORMAT_KIND:
                    format_kind_reg <= cfg_data[ptbp_pkg::KIND_BITS-1:0];
                ptbp_pkg::CFG_FILE_SIZE:
                    file_size_reg <= cfg_data;
                ptbp_pkg::CFG_HEADER_OFFSET:
                    header_offset_reg <= cfg_data;
                ptbp_pkg::CFG_BLOCK_SIZE:
                    block_size_reg <= cfg_data[ptbp_pkg::BLOCK_BITS-1:0];
                ptbp_pkg::CFG_BITRATE_KBPS:
                    bitrate_reg <= cfg_data[ptbp_pkg::BITRATE_BITS-1:0];
                default:
                    ;
            endcase
        end
    end

    // time divisor: frames of block_size at 50 per second, bytes per second,
    // or bitrate in kbit/s scaled to bits per second (unused kind as bitrate)
    assign is_bitrate = !((format_kind_reg == ptbp_pkg::FMT_FRAME) ||
                          (format_kind_reg == ptbp_pkg::FMT_BPS));
    assign bs50   = TW'(block_size_reg) * TW'(ptbp_pkg::FRAMES_PER_SEC);
    assign br1000 = TW'(bitrate_reg) * TW'(ptbp_pkg::MS_PER_SEC);

    always_comb
    begin
        case (format_kind_reg)
            ptbp_pkg::FMT_FRAME: tdiv = DW'(bs50);
            ptbp_pkg::FMT_BPS:   tdiv = DW'(block_size_reg);
            default:             tdiv = DW'(br1000);
        endcase
    end

    assign fs_nz  = (file_size_reg != '0);
    assign div_nz = is_bitrate ? (bitrate_reg != '0) : (block_size_reg != '0);

    // byte counts, clamped at zero below the header
    assign pos_ext    = WX'(pos_reg);
    assign off_ext    = WX'(header_offset_reg);
    assign done_bytes = (pos_ext >= off_ext) ? (pos_ext - off_ext) : '0;
    assign all_bytes  = (file_size_reg >= header_offset_reg) ?
                        (file_size_reg - header_offset_reg) : '0;
    assign done_dvd   = is_bitrate ? (NB'(done_bytes) << ptbp_pkg::BYTE_SHIFT)
                                   : NB'(done_bytes);
    assign all_dvd    = is_bitrate ? (NB'(all_bytes) << ptbp_pkg::BYTE_SHIFT)
                                   : NB'(all_bytes);

    always_comb
    begin
        case (state_reg)
            ptbp_pkg::S_LDE:
            begin
                dividend = done_dvd;
                divisor  = tdiv;
            end
            ptbp_pkg::S_LDT:
            begin
                dividend = all_dvd;
                divisor  = tdiv;
            end
            default:
            begin
                dividend = product;
                divisor  = file_size_reg;
            end
        endcase
    end

    // sequencer
    assign accept = in_valid && !in_stall;
    assign run    = (state_reg == ptbp_pkg::S_MUL)  || (state_reg == ptbp_pkg::S_DIVP) ||
                    (state_reg == ptbp_pkg::S_DIVE) || (state_reg == ptbp_pkg::S_DIVT);
    assign last   = (cnt_reg == CW'(NB - 1));
    assign cnt_next = (run && !last) ? (cnt_reg + 1'b1) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ptbp_pkg::S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        mul_ctl    = '0;
        div_ctl    = '0;
        spl_ctl    = '0;
        in_stall   = 1'b1;
        out_load   = 1'b0;
        case (state_reg)
            ptbp_pkg::S_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    mul_ctl.load = 1'b1;
                    state_next   = ptbp_pkg::S_MUL;
                end
            end
            ptbp_pkg::S_MUL:
            begin
                mul_ctl.step = 1'b1;
                if (last)
                    state_next = ptbp_pkg::S_LDP;
            end
            ptbp_pkg::S_LDP:
            begin
                div_ctl.load = 1'b1;
                state_next   = ptbp_pkg::S_DIVP;
            end
            ptbp_pkg::S_DIVP:
            begin
                div_ctl.step = 1'b1;
                if (last)
                    state_next = ptbp_pkg::S_LDE;
            end
            ptbp_pkg::S_LDE:
            begin
                div_ctl.load = 1'b1;
                spl_ctl.load = 1'b1;
                state_next   = ptbp_pkg::S_DIVE;
            end
            ptbp_pkg::S_DIVE:
            begin
                div_ctl.step = 1'b1;
                spl_ctl.step = 1'b1;
                if (last)
                    state_next = ptbp_pkg::S_LDT;
            end
            ptbp_pkg::S_LDT:
            begin
                div_ctl.load = 1'b1;
                spl_ctl.load = 1'b1;
                state_next   = ptbp_pkg::S_DIVT;
            end
            ptbp_pkg::S_DIVT:
            begin
                div_ctl.step = 1'b1;
                spl_ctl.step = 1'b1;
                if (last)
                    state_next = ptbp_pkg::S_FIN;
            end
            ptbp_pkg::S_FIN:
            begin
                // hand over once the output register is free or draining
                if (!out_valid_reg || !out_stall)
                begin
                    out_load   = 1'b1;
                    state_next = ptbp_pkg::S_IDLE;
                end
            end
            default:
                state_next = ptbp_pkg::S_IDLE;
        endcase
    end

    ptbp_mul100 #(
        .PW (PW),
        .NB (NB)
    ) u_mul (
        .clk      (clk),
        .ctl      (mul_ctl),
        .position (position),
        .product  (product)
    );

    ptbp_div #(
        .NB (NB)
    ) u_div (
        .clk      (clk),
        .ctl      (div_ctl),
        .dividend (dividend),
        .divisor  (divisor),
        .qbit     (qbit)
    );

    ptbp_split60 u_split (
        .clk    (clk),
        .ctl    (spl_ctl),
        .qbit   (qbit),
        .minute (spl_minute),
        .second (spl_second)
    );

    // percent quotient, saturating at full scale
    always_ff @(posedge clk)
    begin
        if (accept)
            pos_reg <= position;
        if (div_ctl.load && state_reg == ptbp_pkg::S_LDP)
        begin
            pct_acc_reg <= '0;
            pct_sat_reg <= 1'b0;
        end
        else if (div_ctl.step && state_reg == ptbp_pkg::S_DIVP)
        begin
            pct_sat_reg <= pct_sat_reg | pct_acc_reg[PB-1];
            pct_acc_reg <= {pct_acc_reg[PB-2:0], qbit};
        end
    end

    assign pct_result = pct_sat_reg ? {PB{1'b1}} : pct_acc_reg;
    assign pct_clear  = ((held_min_reg == '0) && (held_sec_reg == '0)) ||
                        (position == '0);

    // held results: percent kept on zero file size, times kept on zero divisor
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_pct_reg  <= '0;
            held_min_reg  <= '0;
            held_sec_reg  <= '0;
            held_tmin_reg <= '0;
            held_tsec_reg <= '0;
        end
        else
        begin
            if (accept && pct_clear)
                held_pct_reg <= '0;
            else if (state_reg == ptbp_pkg::S_LDE && fs_nz)
                held_pct_reg <= pct_result;
            if (state_reg == ptbp_pkg::S_LDT && div_nz)
            begin
                held_min_reg <= spl_minute;
                held_sec_reg <= spl_second;
            end
            if (state_reg == ptbp_pkg::S_FIN && div_nz)
            begin
                held_tmin_reg <= spl_minute;
                held_tsec_reg <= spl_second;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_load)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            percent_reg <= held_pct_reg;
            minute_reg  <= held_min_reg;
            second_reg  <= held_sec_reg;
            tmin_reg    <= div_nz ? spl_minute : held_tmin_reg;
            tsec_reg    <= div_nz ? spl_second : held_tsec_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign percent      = percent_reg;
    assign minute       = minute_reg;
    assign second       = second_reg;
    assign total_minute = tmin_reg;
    assign total_second = tsec_reg;

`ifndef NO_ASSERTIONS
    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == ptbp_pkg::S_MUL))
        else $error("transfer in did not start the multiply pass");

    a_seconds_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> ((second_reg < SB'(ptbp_pkg::SEC_PER_MIN)) &&
                           (tsec_reg < SB'(ptbp_pkg::SEC_PER_MIN))))
        else $error("seconds field out of range");

    a_fin_delivers: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ptbp_pkg::S_FIN && !(out_valid_reg && out_stall)) |=>
        (out_valid_reg && state_reg == ptbp_pkg::S_IDLE))
        else $error("finished result not handed to the output register");

    a_zero_pos_pct: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && !fs_nz && pos_reg == '0) |=> (percent_reg == '0))
        else $error("percent not cleared for zero position and zero file size");
`endif

endmodule

`default_nettype wire

[rtl/ptbp_mul100.sv]
// ----------------------------------------------------------------------------
// ptbp_mul100: bit-serial multiply by one hundred
// Takes the position LSB first and builds position * 100 one bit per cycle
// in a shift register, using taps at bit offsets 2, 5 and 6.
// ----------------------------------------------------------------------------
`default_nettype none

module ptbp_mul100 #(
    parameter int PW = ptbp_pkg::POSITION_BITS_DEF,
    parameter int NB = ptbp_pkg::POSITION_BITS_DEF + 7
) (
    input  wire logic              clk,
    input  wire ptbp_pkg::seq_ctl_t ctl,
    input  wire logic [PW-1:0]     position,
    output logic      [NB-1:0]     product
);

    logic [PW-1:0] src_reg;
    logic [5:0]    hist_reg;   // hist_reg[i] holds source bit k-1-i
    logic [1:0]    carry_reg;
    logic [NB-1:0] prod_reg;
    logic [2:0]    sum;

    // 100 = 64 + 32 + 4
    assign sum = 3'(hist_reg[1]) + 3'(hist_reg[4]) + 3'(hist_reg[5]) + 3'(carry_reg);

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            src_reg   <= position;
            hist_reg  <= '0;
            carry_reg <= '0;
        end
        else if (ctl.step)
        begin
            src_reg   <= src_reg >> 1;
            hist_reg  <= {hist_reg[4:0], src_reg[0]};
            carry_reg <= sum[2:1];
            prod_reg  <= {sum[0], prod_reg[NB-1:1]};
        end
    end

    assign product = prod_reg;

endmodule

`default_nettype wire

[rtl/ptbp_div.sv]
// ----------------------------------------------------------------------------
// ptbp_div: shared restoring divider, one quotient bit per cycle
// Shifts the dividend out MSB first into a partial remainder and emits each
// quotient bit as it is decided.
// ----------------------------------------------------------------------------
`default_nettype none

module ptbp_div #(
    parameter int NB = ptbp_pkg::POSITION_BITS_DEF + 7
) (
    input  wire logic                              clk,
    input  wire ptbp_pkg::seq_ctl_t                ctl,
    input  wire logic [NB-1:0]                     dividend,
    input  wire logic [ptbp_pkg::DIVISOR_BITS-1:0] divisor,
    output logic                                   qbit
);

    localparam int DW = ptbp_pkg::DIVISOR_BITS;

    logic [NB-1:0] dvd_reg;
    logic [DW-1:0] dsr_reg;
    logic [DW-1:0] rem_reg;
    logic [DW:0]   trial;
    logic [DW:0]   diff;

    assign trial = {rem_reg, dvd_reg[NB-1]};
    assign diff  = trial - {1'b0, dsr_reg};
    assign qbit  = (trial >= {1'b0, dsr_reg});

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            dvd_reg <= dividend;
            dsr_reg <= divisor;
            rem_reg <= '0;
        end
        else if (ctl.step)
        begin
            dvd_reg <= {dvd_reg[NB-2:0], 1'b0};
            rem_reg <= qbit ? diff[DW-1:0] : trial[DW-1:0];
        end
    end

endmodule

`default_nettype wire

[rtl/ptbp_split60.sv]
// ----------------------------------------------------------------------------
// ptbp_split60: serial minutes and seconds split
// Consumes the seconds count MSB first and divides it by sixty on the fly:
// a six-bit remainder gives the seconds, a saturating shift gives minutes.
// ----------------------------------------------------------------------------
`default_nettype none

module ptbp_split60 (
    input  wire logic                             clk,
    input  wire ptbp_pkg::seq_ctl_t               ctl,
    input  wire logic                             qbit,
    output logic [ptbp_pkg::MINUTE_BITS-1:0]      minute,
    output logic [ptbp_pkg::SECOND_BITS-1:0]      second
);

    localparam int MB = ptbp_pkg::MINUTE_BITS;
    localparam int SB = ptbp_pkg::SECOND_BITS;

    logic [SB-1:0] rem_reg;
    logic [MB-1:0] min_reg;
    logic          sat_reg;
    logic [SB:0]   trial;
    logic          take;
    logic [SB:0]   diff;

    assign trial = {rem_reg, qbit};
    assign take  = (trial >= (SB+1)'(ptbp_pkg::SEC_PER_MIN));
    assign diff  = trial - (SB+1)'(ptbp_pkg::SEC_PER_MIN);

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            rem_reg <= '0;
            min_reg <= '0;
            sat_reg <= 1'b0;
        end
        else if (ctl.step)
        begin
            rem_reg <= take ? diff[SB-1:0] : trial[SB-1:0];
            // a set bit shifted off the top means the minutes overflowed
            sat_reg <= sat_reg | min_reg[MB-1];
            min_reg <= {min_reg[MB-2:0], take};
        end
    end

    assign minute = sat_reg ? {MB{1'b1}} : min_reg;
    assign second = rem_reg;

endmodule

`default_nettype wire

[tb/tb_play_time_from_byte_position.sv]
// ----------------------------------------------------------------------------
// tb_play_time_from_byte_position: self-checking bench for the play-time block
// Walks a short directed table (reset values, extremes, zero file size, zero
// divisor, positions below the header, the unused format kind) and then
// random register settings with positions mostly inside the file.  Each
// transfer in is predicted here and each transfer out is compared with the
// oldest prediction, field by field.  Both channels idle at random.
// ----------------------------------------------------------------------------
module tb_play_time_from_byte_position;

    timeunit 1ns;
    timeprecision 1ps;

    import ptbp_pkg::*;

    localparam int PW = POSITION_BITS_DEF;
    localparam int IDLE_PCT = 37;
    localparam int PHASES = 20;
    localparam int PHASE_ITEMS = 50;
    localparam int SETTLE_CYCLES = 200;
    localparam longint CYCLE_LIMIT = 4_000_000;
    localparam logic [KIND_BITS-1:0] FMT_UNUSED = 2'd3;
    localparam logic [SIZE_BITS-1:0] MAXB = 40'hFF_FFFF_FFFF;

    typedef struct packed {
        logic [PERCENT_BITS-1:0] percent;
        logic [MINUTE_BITS-1:0]  minute;
        logic [SECOND_BITS-1:0]  second;
        logic [MINUTE_BITS-1:0]  total_minute;
        logic [SECOND_BITS-1:0]  total_second;
    } readout_t;

    typedef struct packed {
        logic [KIND_BITS-1:0]    kind;
        logic [SIZE_BITS-1:0]    file_size;
        logic [SIZE_BITS-1:0]    offset;
        logic [BLOCK_BITS-1:0]   block;
        logic [BITRATE_BITS-1:0] bitrate;
    } settings_t;

    typedef struct packed {
        bit        load;
        settings_t cfg;
        logic [PW-1:0] pos;
        bit        pinned;
        readout_t  res;
    } row_t;

    typedef struct packed {
        bit       pinned;
        readout_t res;
    } pin_t;

    localparam int DIR_COUNT = 23;
    localparam row_t DIR_ROWS [DIR_COUNT] = '{
        // straight after reset: bitrate based with no bitrate, nothing moves
        '{1'b0, '0, 40'd12345, 1'b1, '{8'd0, 16'd0, 6'd0, 16'd0, 6'd0}},
        '{1'b0, '0, MAXB, 1'b1, '{8'd0, 16'd0, 6'd0, 16'd0, 6'd0}},
        // bytes per second, 1000 s file
        '{1'b1, '{FMT_BPS, 40'd1000000, 40'd0, 20'd1000, 16'd0}, 40'd0, 1'b1,
          '{8'd0, 16'd0, 6'd0, 16'd16, 6'd40}},
        '{1'b0, '0, 40'd500000, 1'b1, '{8'd50, 16'd8, 6'd20, 16'd16, 6'd40}},
        '{1'b0, '0, 40'd1000000, 1'b1, '{8'd100, 16'd16, 6'd40, 16'd16, 6'd40}},
        '{1'b0, '0, 40'd2999999, 1'b0, '0},
        '{1'b0, '0, 40'd3000000, 1'b1, '{8'd255, 16'd50, 6'd0, 16'd16, 6'd40}},
        // frames with a header; first position sits inside the header
        '{1'b1, '{FMT_FRAME, 40'd5000000, 40'd1000000, 20'd400, 16'd0}, 40'd500000, 1'b1,
          '{8'd10, 16'd0, 6'd0, 16'd3, 6'd20}},
        '{1'b0, '0, 40'd3000000, 1'b1, '{8'd60, 16'd1, 6'd40, 16'd3, 6'd20}},
        // zero block size: times hold
        '{1'b1, '{FMT_BPS, 40'd2000000, 40'd0, 20'd0, 16'd0}, 40'd1000000, 1'b1,
          '{8'd50, 16'd1, 6'd40, 16'd3, 6'd20}},
        // zero file size: percent holds, then clears on position zero
        '{1'b1, '{FMT_BITRATE, 40'd0, 40'd0, 20'd0, 16'd128}, 40'd1600000, 1'b1,
          '{8'd50, 16'd1, 6'd40, 16'd0, 6'd0}},
        '{1'b0, '0, 40'd0, 1'b1, '{8'd0, 16'd0, 6'd0, 16'd0, 6'd0}},
        '{1'b0, '0, 40'd16000, 1'b1, '{8'd0, 16'd0, 6'd1, 16'd0, 6'd0}},
        // percent set with time at 0:00; with size zero next, the held 0:00 clears it
        '{1'b1, '{FMT_BPS, 40'd1000, 40'd0, 20'd1000000, 16'd128}, 40'd500, 1'b1,
          '{8'd50, 16'd0, 6'd0, 16'd0, 6'd0}},
        '{1'b1, '{FMT_BPS, 40'd0, 40'd0, 20'd1000000, 16'd128}, 40'd700, 1'b1,
          '{8'd0, 16'd0, 6'd0, 16'd0, 6'd0}},
        // unused kind divides by the bitrate, not the block size
        '{1'b1, '{FMT_UNUSED, 40'd3600000, 40'd0, 20'd0, 16'd8}, 40'd90000, 1'b1,
          '{8'd2, 16'd1, 6'd30, 16'd60, 6'd0}},
        '{1'b1, '{FMT_BPS, MAXB, 40'd0, 20'd1, 16'hFFFF}, MAXB, 1'b1,
          '{8'd100, 16'hFFFF, 6'd15, 16'hFFFF, 6'd15}},
        '{1'b1, '{FMT_BITRATE, MAXB, MAXB, 20'hFFFFF, 16'hFFFF}, 40'd0, 1'b1,
          '{8'd0, 16'd0, 6'd0, 16'd0, 6'd0}},
        '{1'b0, '0, MAXB, 1'b1, '{8'd100, 16'd0, 6'd0, 16'd0, 6'd0}},
        // file shorter than its header
        '{1'b1, '{FMT_FRAME, 40'd1, 40'd1000, 20'hFFFFF, 16'd0}, MAXB, 1'b0, '0},
        '{1'b1, '{FMT_BITRATE, MAXB, 40'd0, 20'd7, 16'd1}, MAXB, 1'b0, '0},
        '{1'b1, '{FMT_FRAME, MAXB, 40'd0, 20'd1, 16'd0}, MAXB, 1'b0, '0},
        '{1'b0, '0, 40'd123456789, 1'b0, '0}
    };

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      in_valid = 1'b0;
    logic                      in_stall;
    logic [PW-1:0]             position = '0;
    logic                      out_valid;
    logic                      out_stall = 1'b0;
    logic [PERCENT_BITS-1:0]   percent;
    logic [MINUTE_BITS-1:0]    minute;
    logic [SECOND_BITS-1:0]    second;
    logic [MINUTE_BITS-1:0]    total_minute;
    logic [SECOND_BITS-1:0]    total_second;
    logic                      cfg_valid = 1'b0;
    logic                      cfg_ready;
    logic [CFG_INDEX_BITS-1:0] cfg_index = CFG_FORMAT_KIND;
    logic [SIZE_BITS-1:0]      cfg_data = '0;

    // register copy and held results seen by the predictor
    logic [KIND_BITS-1:0]    cfg_kind = FMT_BITRATE;
    logic [SIZE_BITS-1:0]    cfg_file = '0;
    logic [SIZE_BITS-1:0]    cfg_offset = '0;
    logic [BLOCK_BITS-1:0]   cfg_block = '0;
    logic [BITRATE_BITS-1:0] cfg_bitrate = '0;
    logic [PERCENT_BITS-1:0] keep_pct = '0;
    logic [MINUTE_BITS-1:0]  keep_min = '0;
    logic [SECOND_BITS-1:0]  keep_sec = '0;
    logic [MINUTE_BITS-1:0]  keep_tmin = '0;
    logic [SECOND_BITS-1:0]  keep_tsec = '0;

    settings_t cur = '0;
    bit        steady = 1'b0;
    readout_t  readout_q[$];
    pin_t      pin_q[$];
    int        mismatch_count = 0;
    int        results_checked = 0;
    int        positions_sent = 0;
    int        settings_applied = 0;
    int        long_stall = 0;
    longint    cycles = 0;

    play_time_from_byte_position dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .position     (position),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .percent      (percent),
        .minute       (minute),
        .second       (second),
        .total_minute (total_minute),
        .total_second (total_second),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Timed out after %0d cycles with %0d results pending",
                     cycles, readout_q.size());
            $display("FAILURE");
            $finish;
        end
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [63:0] audio_seconds(input logic [63:0] bytes,
                                                  input logic [KIND_BITS-1:0] kind,
                                                  input logic [63:0] div);
        if (kind == FMT_FRAME)
            return bytes / div / FRAMES_PER_SEC;
        if (kind == FMT_BPS)
            return bytes / div;
        return ((bytes << BYTE_SHIFT) / div) / MS_PER_SEC;
    endfunction

    function automatic logic [MINUTE_BITS+SECOND_BITS-1:0] as_min_sec(input logic [63:0] secs);
        logic [63:0] mins;
        mins = secs / SEC_PER_MIN;
        return {(mins > 64'hFFFF) ? 16'hFFFF : mins[MINUTE_BITS-1:0],
                SECOND_BITS'(secs % SEC_PER_MIN)};
    endfunction

    function automatic readout_t predict_play_time(input logic [PW-1:0] pos_in);
        logic [63:0] pos;
        logic [63:0] div;
        logic [63:0] done;
        logic [63:0] whole;
        logic [63:0] pct;
        pos = 64'(pos_in);
        div = (cfg_kind == FMT_FRAME || cfg_kind == FMT_BPS) ? 64'(cfg_block)
                                                              : 64'(cfg_bitrate);
        if ((keep_min == 0 && keep_sec == 0) || pos == 0)
            keep_pct = '0;
        if (cfg_file != 0)
        begin
            pct = (pos / cfg_file >= 3) ? 64'd255 : pos * PERCENT_SCALE / cfg_file;
            keep_pct = (pct > 255) ? 8'hFF : pct[PERCENT_BITS-1:0];
        end
        if (div != 0)
        begin
            // clamp both byte counts at the header
            done = (pos >= cfg_offset) ? pos - cfg_offset : 64'd0;
            whole = (cfg_file >= cfg_offset) ? 64'(cfg_file - cfg_offset) : 64'd0;
            {keep_min, keep_sec} = as_min_sec(audio_seconds(done, cfg_kind, div));
            {keep_tmin, keep_tsec} = as_min_sec(audio_seconds(whole, cfg_kind, div));
        end
        return '{keep_pct, keep_min, keep_sec, keep_tmin, keep_tsec};
    endfunction

    task automatic log_mismatch(input string text);
        mismatch_count++;
        if (mismatch_count <= 40)
            $display("%0t: mismatch: %s", $realtime, text);
    endtask

    task automatic compare_readout(input readout_t got, input readout_t want);
        if (got.percent !== want.percent)
            log_mismatch($sformatf("percent %0d, expected %0d", got.percent, want.percent));
        if (got.minute !== want.minute)
            log_mismatch($sformatf("minute %0d, expected %0d", got.minute, want.minute));
        if (got.second !== want.second)
            log_mismatch($sformatf("second %0d, expected %0d", got.second, want.second));
        if (got.total_minute !== want.total_minute)
            log_mismatch($sformatf("total_minute %0d, expected %0d",
                                   got.total_minute, want.total_minute));
        if (got.total_second !== want.total_second)
            log_mismatch($sformatf("total_second %0d, expected %0d",
                                   got.total_second, want.total_second));
    endtask

    always @(posedge clk)
    begin : watch
        readout_t got;
        readout_t want;
        pin_t     pin;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_FORMAT_KIND:   cfg_kind = cfg_data[KIND_BITS-1:0];
                    CFG_FILE_SIZE:     cfg_file = cfg_data;
                    CFG_HEADER_OFFSET: cfg_offset = cfg_data;
                    CFG_BLOCK_SIZE:    cfg_block = cfg_data[BLOCK_BITS-1:0];
                    CFG_BITRATE_KBPS:  cfg_bitrate = cfg_data[BITRATE_BITS-1:0];
                    default: ;
                endcase
            end
            if (in_valid && !in_stall)
            begin
                pin = pin_q.pop_front();
                want = predict_play_time(position);
                if (pin.pinned)
                    want = pin.res;
                readout_q.push_back(want);
                positions_sent++;
            end
            if (out_valid && !out_stall)
            begin
                got = '{percent, minute, second, total_minute, total_second};
                if (readout_q.size() == 0)
                    log_mismatch("result transfer with nothing pending");
                else
                    compare_readout(got, readout_q.pop_front());
                results_checked++;
            end
        end
    end

    // receiver: short random stalls, now and then a long one
    always @(posedge clk)
    begin
        if (long_stall != 0)
        begin
            long_stall <= long_stall - 1;
            out_stall <= 1'b1;
        end
        else if (!steady && $urandom_range(0, 1999) == 0)
        begin
            long_stall <= $urandom_range(100, 400);
            out_stall <= 1'b1;
        end
        else
            out_stall <= !steady && ($urandom_range(0, 99) < IDLE_PCT);
    end

    task automatic send_position(input logic [PW-1:0] pos, input bit pinned,
                                 input readout_t res);
        while (!steady && $urandom_range(0, 99) < IDLE_PCT)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        if (!steady && $urandom_range(0, 99) < 4)
        begin
            repeat ($urandom_range(1, 250))
            begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
        end
        pin_q.push_back('{pinned, res});
        in_valid <= 1'b1;
        position <= pos;
        do @(posedge clk); while (in_stall);
    endtask

    // let the last transfer in be queued before waiting for the results to empty
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (readout_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [SIZE_BITS-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge clk); while (!cfg_ready);
    endtask

    task automatic apply_settings(input settings_t s);
        write_reg(CFG_FORMAT_KIND, SIZE_BITS'(s.kind));
        write_reg(CFG_FILE_SIZE, s.file_size);
        write_reg(CFG_HEADER_OFFSET, s.offset);
        write_reg(CFG_BLOCK_SIZE, SIZE_BITS'(s.block));
        write_reg(CFG_BITRATE_KBPS, SIZE_BITS'(s.bitrate));
        cfg_valid <= 1'b0;
        cur = s;
        settings_applied++;
    endtask

    function automatic settings_t draw_settings();
        settings_t   s;
        int unsigned pick;
        pick = $urandom_range(0, 99);
        s.kind = (pick < 6) ? FMT_UNUSED : KIND_BITS'($urandom_range(0, 2));
        pick = $urandom_range(0, 99);
        if (pick < 10)
            s.file_size = '0;
        else if (pick < 20)
            s.file_size = SIZE_BITS'(rand64());
        else if (pick < 30)
            s.file_size = SIZE_BITS'($urandom_range(1, 65535));
        else
            s.file_size = SIZE_BITS'($urandom_range(100000, 400000000));
        pick = $urandom_range(0, 99);
        if (pick < 40)
            s.offset = '0;
        else if (pick < 75)
            s.offset = SIZE_BITS'($urandom_range(0, 65535));
        else if (pick < 85)
            s.offset = SIZE_BITS'(rand64());
        else
            s.offset = s.file_size + SIZE_BITS'($urandom_range(0, 1000));
        pick = $urandom_range(0, 99);
        if (pick < 10)
            s.block = '0;
        else if (pick < 18)
            s.block = BLOCK_BITS'(1);
        else if (pick < 30)
            s.block = BLOCK_BITS'($urandom);
        else
            s.block = BLOCK_BITS'($urandom_range(100, 4000));
        pick = $urandom_range(0, 99);
        if (pick < 10)
            s.bitrate = '0;
        else if (pick < 15)
            s.bitrate = BITRATE_BITS'(1);
        else if (pick < 27)
            s.bitrate = BITRATE_BITS'($urandom);
        else
            s.bitrate = BITRATE_BITS'($urandom_range(8, 320));
        return s;
    endfunction

    function automatic logic [PW-1:0] pick_position();
        logic [63:0] span;
        int unsigned pick;
        pick = $urandom_range(0, 99);
        span = 64'(cur.file_size) + 64'(cur.file_size >> 2) + 64'd1;
        if (pick < 10)
            return PW'(rand64());
        if (pick < 15)
            return '0;
        if (pick < 22)
            return PW'(64'(cur.offset) + 64'($urandom_range(0, 4)) - 64'd2);
        if (pick < 27)
            return PW'(64'(cur.file_size) + 64'($urandom_range(0, 2)) - 64'd1);
        return PW'(rand64() % span);
    endfunction

    initial
    begin
        int phase;
        int n;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int r = 0; r < DIR_COUNT; r++)
        begin
            if (DIR_ROWS[r].load)
            begin
                drain();
                apply_settings(DIR_ROWS[r].cfg);
            end
            send_position(DIR_ROWS[r].pos, DIR_ROWS[r].pinned, DIR_ROWS[r].res);
        end

        for (phase = 0; phase < PHASES; phase++)
        begin
            drain();
            apply_settings(draw_settings());
            // hold both sides busy for two whole phases
            steady = (phase == 8 || phase == 9);
            for (n = 0; n < PHASE_ITEMS; n++)
                send_position(pick_position(), 1'b0, '0);
        end
        steady = 1'b0;

        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        while (readout_q.size() != 0)
        begin
            void'(readout_q.pop_front());
            log_mismatch("expected result never arrived");
        end

        $display("Checked %0d results from %0d positions over %0d register settings,",
                 results_checked, positions_sent, settings_applied);
        $display("all four format kinds, zero sizes and divisors, and saturating values.");
        if (mismatch_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

[sim.f]
rtl/ptbp_pkg.sv
rtl/ptbp_mul100.sv
rtl/ptbp_div.sv
rtl/ptbp_split60.sv
rtl/play_time_from_byte_position.sv
tb/tb_play_time_from_byte_position.sv
